// ===== src/mme_pkg.sv =====
// Shared types and constants for the matrix multiply engine.
// Depends on nothing; every other file in src but mme_store refers to it by scoped names.
`default_nettype none

package mme_pkg;

   // Default configuration of the engine
   localparam int MAX_DIM_DEF   = 8;
   localparam int ELEM_BITS_DEF = 16;

   // Fixed field widths of the channels
   localparam int OPCODE_W  = 2;
   localparam int IDX_W     = 3;
   localparam int VALUE_W   = 16;
   localparam int RESULT_W  = 32;
   localparam int DIM_W     = 4;
   localparam int CSR_IDX_W = 2;

   // Register indexes on the csr channel
   localparam logic [CSR_IDX_W-1:0] REG_A_ROWS    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_INNER_DIM = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_B_COLS    = 2'd2;

   // Reset value of every dimension register
   localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;

   typedef enum logic [OPCODE_W-1:0] {
      OP_WRITE_A = 2'd0,
      OP_WRITE_B = 2'd1,
      OP_COMPUTE = 2'd2
   } mme_op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_DRAIN
   } mme_state_type;

   // Sequencer to datapath control
   typedef struct packed {
      logic             rd_issue;
      logic             acc_clear;
      logic             emit;
      logic [IDX_W-1:0] out_row;
      logic [IDX_W-1:0] out_col;
      logic             last;
   } mme_ctrl_type;

   // Datapath to sequencer status
   typedef struct packed {
      logic pipe_busy;
      logic out_free;
   } mme_status_type;

endpackage

`default_nettype wire

// ===== src/mme_ifs.sv =====
// Channel interfaces of the matrix multiply engine: load/compute requests,
// product results and register writes. Depends on mme_pkg for field widths.
`default_nettype none

interface mme_req_if;
   logic                              valid;
   logic                              ready;
   logic [mme_pkg::OPCODE_W-1:0]      opcode;
   logic [mme_pkg::IDX_W-1:0]         row_index;
   logic [mme_pkg::IDX_W-1:0]         col_index;
   logic signed [mme_pkg::VALUE_W-1:0] element_value;

   modport source (output valid, opcode, row_index, col_index, element_value,
                   input ready);
   modport sink   (input valid, opcode, row_index, col_index, element_value,
                   output ready);
endinterface

interface mme_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [mme_pkg::IDX_W-1:0]          out_row;
   logic [mme_pkg::IDX_W-1:0]          out_col;
   logic signed [mme_pkg::RESULT_W-1:0] product_value;
   logic                               saturated;
   logic                               last;

   modport source (output valid, out_row, out_col, product_value, saturated, last,
                   input ready);
   modport sink   (input valid, out_row, out_col, product_value, saturated, last,
                   output ready);
endinterface

interface mme_csr_if;
   logic                           valid;
   logic                           ready;
   logic [mme_pkg::CSR_IDX_W-1:0]  reg_index;
   logic [mme_pkg::DIM_W-1:0]      wr_data;

   modport source (output valid, reg_index, wr_data, input ready);
   modport sink   (input valid, reg_index, wr_data, output ready);
endinterface

`default_nettype wire

// ===== src/matrix_multiply_engine.sv =====
// Top level of the matrix multiply engine: dimension registers, operand
// stores, sequencer and MAC datapath. Depends on mme_pkg, mme_ifs, mme_store,
// mme_sequencer and mme_mac.
// Usage:
//   req_bus carries one item per transfer. Opcode OP_WRITE_A / OP_WRITE_B
//   write one element of A or B at (row_index, col_index); writes outside the
//   configured dimensions are dropped. OP_COMPUTE emits every element of
//   C = A x B on rsp_bus in row-major order, last set on the final one.
//   csr_bus writes a_rows, inner_dim, b_cols (indexes 0, 1, 2); it is always
//   ready and values above MAX_DIM act as MAX_DIM.
// Timing:
//   Element writes are taken back to back while idle. A compute item is taken
//   while idle; then for each product element the sequencer issues one store
//   read per inner step (none when inner_dim is zero) on the single read port
//   of each store, then the multiplier and accumulator stages drain.
//   req_bus.ready is low until the last product element sits in the output reg.
// Reset and stall:
//   Synchronous reset sets all dimensions to 8 and empties the pipe; store
//   contents are undefined until written. When rsp_bus stalls, the output
//   register holds its element and the sequencer waits before emitting the next.
`default_nettype none

module matrix_multiply_engine #(
   parameter int MAX_DIM   = mme_pkg::MAX_DIM_DEF,
   parameter int ELEM_BITS = mme_pkg::ELEM_BITS_DEF
) (
   input  wire logic  clock,
   input  wire logic  reset,
   mme_req_if.sink    req_bus,
   mme_rsp_if.source  rsp_bus,
   mme_csr_if.sink    csr_bus
);

   localparam int AW = $clog2(MAX_DIM * MAX_DIM);
   localparam logic [mme_pkg::DIM_W-1:0] DIM_MAX = mme_pkg::DIM_W'(MAX_DIM);

   logic [mme_pkg::DIM_W-1:0] a_rows_ff;
   logic [mme_pkg::DIM_W-1:0] inner_dim_ff;
   logic [mme_pkg::DIM_W-1:0] b_cols_ff;
   logic [mme_pkg::DIM_W-1:0] num_rows;
   logic [mme_pkg::DIM_W-1:0] num_inner;
   logic [mme_pkg::DIM_W-1:0] num_cols;

   logic                        idle;
   logic                        req_xfer;
   logic                        start;
   logic                        a_wr_en;
   logic                        b_wr_en;
   logic [AW-1:0]               wr_addr;
   logic signed [31:0]          value_ext;
   logic signed [ELEM_BITS-1:0] wr_elem;
   logic [mme_pkg::DIM_W-1:0]   row_ext;
   logic [mme_pkg::DIM_W-1:0]   col_ext;
   logic [AW-1:0]               a_rd_addr;
   logic [AW-1:0]               b_rd_addr;
   logic signed [ELEM_BITS-1:0] a_data;
   logic signed [ELEM_BITS-1:0] b_data;

   mme_pkg::mme_ctrl_type   ctrl;
   mme_pkg::mme_status_type status;

   // Dimension registers
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_rows_ff    <= mme_pkg::DIM_RESET;
         inner_dim_ff <= mme_pkg::DIM_RESET;
         b_cols_ff    <= mme_pkg::DIM_RESET;
      end else if (csr_bus.valid) begin
         case (csr_bus.reg_index)
            mme_pkg::REG_A_ROWS:    a_rows_ff    <= csr_bus.wr_data;
            mme_pkg::REG_INNER_DIM: inner_dim_ff <= csr_bus.wr_data;
            mme_pkg::REG_B_COLS:    b_cols_ff    <= csr_bus.wr_data;
            default: begin
            end
         endcase
      end
   end

   // Clip dimensions to the store size
   assign num_rows  = (a_rows_ff > DIM_MAX)    ? DIM_MAX : a_rows_ff;
   assign num_inner = (inner_dim_ff > DIM_MAX) ? DIM_MAX : inner_dim_ff;
   assign num_cols  = (b_cols_ff > DIM_MAX)    ? DIM_MAX : b_cols_ff;

   // Decode the request
   assign req_bus.ready = idle;
   assign req_xfer      = req_bus.valid && req_bus.ready;
   assign row_ext       = mme_pkg::DIM_W'(req_bus.row_index);
   assign col_ext       = mme_pkg::DIM_W'(req_bus.col_index);
   assign value_ext     = 32'(req_bus.element_value);
   assign wr_elem       = value_ext[ELEM_BITS-1:0];
   assign wr_addr       = AW'(int'(req_bus.row_index) * MAX_DIM + int'(req_bus.col_index));

   always_comb begin
      a_wr_en = 1'b0;
      b_wr_en = 1'b0;
      start   = 1'b0;
      case (mme_pkg::mme_op_type'(req_bus.opcode))
         mme_pkg::OP_WRITE_A: a_wr_en = req_xfer && (row_ext < num_rows) &&
                                        (col_ext < num_inner);
         mme_pkg::OP_WRITE_B: b_wr_en = req_xfer && (row_ext < num_inner) &&
                                        (col_ext < num_cols);
         mme_pkg::OP_COMPUTE: start   = req_xfer;
         default: begin
         end
      endcase
   end

   mme_store #(
      .MAX_DIM   (MAX_DIM),
      .ELEM_BITS (ELEM_BITS)
   ) u_a_store (
      .clock   (clock),
      .wr_en   (a_wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_elem),
      .rd_en   (ctrl.rd_issue),
      .rd_addr (a_rd_addr),
      .rd_data (a_data)
   );

   mme_store #(
      .MAX_DIM   (MAX_DIM),
      .ELEM_BITS (ELEM_BITS)
   ) u_b_store (
      .clock   (clock),
      .wr_en   (b_wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_elem),
      .rd_en   (ctrl.rd_issue),
      .rd_addr (b_rd_addr),
      .rd_data (b_data)
   );

   mme_sequencer #(
      .MAX_DIM (MAX_DIM)
   ) u_sequencer (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .num_rows  (num_rows),
      .num_inner (num_inner),
      .num_cols  (num_cols),
      .status    (status),
      .idle      (idle),
      .a_rd_addr (a_rd_addr),
      .b_rd_addr (b_rd_addr),
      .ctrl      (ctrl)
   );

   mme_mac #(
      .MAX_DIM   (MAX_DIM),
      .ELEM_BITS (ELEM_BITS)
   ) u_mac (
      .clock   (clock),
      .reset   (reset),
      .a_data  (a_data),
      .b_data  (b_data),
      .ctrl    (ctrl),
      .status  (status),
      .rsp_bus (rsp_bus)
   );

endmodule

`default_nettype wire

// ===== src/mme_store.sv =====
// Matrix element store: one write port, one read port, registered read data.
// Depends on nothing outside itself; sized by the top level's parameters.
`default_nettype none

module mme_store #(
   parameter int MAX_DIM   = 8,
   parameter int ELEM_BITS = 16
) (
   input  wire logic                        clock,
   input  wire logic                        wr_en,
   input  wire logic [$clog2(MAX_DIM*MAX_DIM)-1:0] wr_addr,
   input  wire logic signed [ELEM_BITS-1:0] wr_data,
   input  wire logic                        rd_en,
   input  wire logic [$clog2(MAX_DIM*MAX_DIM)-1:0] rd_addr,
   output logic signed [ELEM_BITS-1:0]      rd_data
);

   localparam int DEPTH = MAX_DIM * MAX_DIM;

   logic signed [ELEM_BITS-1:0] mem [DEPTH];
   logic signed [ELEM_BITS-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port, registered read data
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== src/mme_sequencer.sv =====
// Compute sequencer: walks rows, columns and the inner index, issues store
// reads and tells the datapath when to clear and emit. Depends on mme_pkg.
`default_nettype none

module mme_sequencer #(
   parameter int MAX_DIM = mme_pkg::MAX_DIM_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [mme_pkg::DIM_W-1:0]     num_rows,
   input  wire logic [mme_pkg::DIM_W-1:0]     num_inner,
   input  wire logic [mme_pkg::DIM_W-1:0]     num_cols,
   input  wire mme_pkg::mme_status_type       status,
   output logic                               idle,
   output logic [$clog2(MAX_DIM*MAX_DIM)-1:0] a_rd_addr,
   output logic [$clog2(MAX_DIM*MAX_DIM)-1:0] b_rd_addr,
   output mme_pkg::mme_ctrl_type              ctrl
);

   localparam int IW = $clog2(MAX_DIM);
   localparam int AW = $clog2(MAX_DIM * MAX_DIM);

   mme_pkg::mme_state_type state_ff, state_in;
   logic [IW-1:0] r_ff, r_in;
   logic [IW-1:0] c_ff, c_in;
   logic [IW-1:0] k_ff, k_in;

   logic empty_run;
   logic last_k;
   logic last_c;
   logic last_elem;
   logic emit_now;

   assign empty_run = (num_rows == '0) || (num_cols == '0);
   assign last_k    = (mme_pkg::DIM_W'(k_ff) + 1'b1) == num_inner;
   assign last_c    = (mme_pkg::DIM_W'(c_ff) + 1'b1) == num_cols;
   assign last_elem = last_c && ((mme_pkg::DIM_W'(r_ff) + 1'b1) == num_rows);
   assign emit_now  = (state_ff == mme_pkg::ST_DRAIN) && !status.pipe_busy &&
                      status.out_free;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mme_pkg::ST_IDLE: begin
            if (start && !empty_run) begin
               state_in = (num_inner == '0) ? mme_pkg::ST_DRAIN : mme_pkg::ST_READ;
            end
         end
         mme_pkg::ST_READ: begin
            if (last_k) begin
               state_in = mme_pkg::ST_DRAIN;
            end
         end
         mme_pkg::ST_DRAIN: begin
            if (emit_now) begin
               if (last_elem) begin
                  state_in = mme_pkg::ST_IDLE;
               end else if (num_inner != '0) begin
                  state_in = mme_pkg::ST_READ;
               end
            end
         end
         default: begin
            state_in = mme_pkg::ST_IDLE;
         end
      endcase
   end

   // Outputs
   always_comb begin
      idle           = (state_ff == mme_pkg::ST_IDLE);
      ctrl.rd_issue  = (state_ff == mme_pkg::ST_READ);
      ctrl.acc_clear = (idle && start) || emit_now;
      ctrl.emit      = emit_now;
      ctrl.out_row   = mme_pkg::IDX_W'(r_ff);
      ctrl.out_col   = mme_pkg::IDX_W'(c_ff);
      ctrl.last      = last_elem;
      a_rd_addr      = AW'(int'(r_ff) * MAX_DIM + int'(k_ff));
      b_rd_addr      = AW'(int'(k_ff) * MAX_DIM + int'(c_ff));
   end

   // Index counters
   always_comb begin
      r_in = r_ff;
      c_in = c_ff;
      k_in = k_ff;
      if (state_ff == mme_pkg::ST_IDLE) begin
         r_in = '0;
         c_in = '0;
         k_in = '0;
      end else if (state_ff == mme_pkg::ST_READ) begin
         if (!last_k) begin
            k_in = k_ff + 1'b1;
         end
      end else if (emit_now) begin
         k_in = '0;
         if (last_c) begin
            c_in = '0;
            r_in = r_ff + 1'b1;
         end else begin
            c_in = c_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mme_pkg::ST_IDLE;
         r_ff     <= '0;
         c_ff     <= '0;
         k_ff     <= '0;
      end else begin
         state_ff <= state_in;
         r_ff     <= r_in;
         c_ff     <= c_in;
         k_ff     <= k_in;
      end
   end

endmodule

`default_nettype wire

// ===== src/mme_mac.sv =====
// Multiply-accumulate datapath with saturation and the result output register.
// Depends on mme_pkg and the mme_rsp_if interface.
`default_nettype none

module mme_mac #(
   parameter int MAX_DIM   = mme_pkg::MAX_DIM_DEF,
   parameter int ELEM_BITS = mme_pkg::ELEM_BITS_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic signed [ELEM_BITS-1:0] a_data,
   input  wire logic signed [ELEM_BITS-1:0] b_data,
   input  wire mme_pkg::mme_ctrl_type       ctrl,
   output mme_pkg::mme_status_type          status,
   mme_rsp_if.source                        rsp_bus
);

   localparam int PROD_W = 2 * ELEM_BITS;
   localparam int ACC_W  = PROD_W + $clog2(MAX_DIM);
   localparam int EXT_W  = (ACC_W > mme_pkg::RESULT_W + 1) ? ACC_W : mme_pkg::RESULT_W + 1;
   localparam logic signed [EXT_W-1:0] SAT_HI =
      EXT_W'(signed'({1'b0, {(mme_pkg::RESULT_W-1){1'b1}}}));
   localparam logic signed [EXT_W-1:0] SAT_LO =
      EXT_W'(signed'({1'b1, {(mme_pkg::RESULT_W-1){1'b0}}}));

   logic                      rd_vld_ff;
   logic                      mul_vld_ff;
   logic signed [PROD_W-1:0]  prod_ff, prod_in;
   logic signed [ACC_W-1:0]   acc_ff;
   logic signed [EXT_W-1:0]   acc_ext;
   logic                      sat_hi;
   logic                      sat_lo;
   logic signed [mme_pkg::RESULT_W-1:0] clamped;

   logic                      out_vld_ff;
   logic [mme_pkg::IDX_W-1:0] out_row_ff;
   logic [mme_pkg::IDX_W-1:0] out_col_ff;
   logic signed [mme_pkg::RESULT_W-1:0] out_value_ff;
   logic                      out_sat_ff;
   logic                      out_last_ff;

   // Track read data and product through the pipe
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff  <= 1'b0;
         mul_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff  <= ctrl.rd_issue;
         mul_vld_ff <= rd_vld_ff;
      end
   end

   // Multiply the two store outputs
   assign prod_in = PROD_W'(a_data) * PROD_W'(b_data);

   always_ff @(posedge clock) begin
      if (rd_vld_ff) begin
         prod_ff <= prod_in;
      end
   end

   // Accumulate the dot product
   always_ff @(posedge clock) begin
      if (ctrl.acc_clear) begin
         acc_ff <= '0;
      end else if (mul_vld_ff) begin
         acc_ff <= acc_ff + ACC_W'(prod_ff);
      end
   end

   // Clamp the finished sum to 32 bits
   assign acc_ext = EXT_W'(acc_ff);
   assign sat_hi  = acc_ext > SAT_HI;
   assign sat_lo  = acc_ext < SAT_LO;
   assign clamped = sat_hi ? SAT_HI[mme_pkg::RESULT_W-1:0] :
                    sat_lo ? SAT_LO[mme_pkg::RESULT_W-1:0] :
                             acc_ext[mme_pkg::RESULT_W-1:0];

   // Output register: load on emit, drop on transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (ctrl.emit) begin
         out_vld_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         out_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.emit) begin
         out_row_ff   <= ctrl.out_row;
         out_col_ff   <= ctrl.out_col;
         out_value_ff <= clamped;
         out_sat_ff   <= sat_hi || sat_lo;
         out_last_ff  <= ctrl.last;
      end
   end

   assign rsp_bus.valid         = out_vld_ff;
   assign rsp_bus.out_row       = out_row_ff;
   assign rsp_bus.out_col       = out_col_ff;
   assign rsp_bus.product_value = out_value_ff;
   assign rsp_bus.saturated     = out_sat_ff;
   assign rsp_bus.last          = out_last_ff;

   assign status.pipe_busy = rd_vld_ff || mul_vld_ff;
   assign status.out_free  = !out_vld_ff || rsp_bus.ready;

endmodule

`default_nettype wire
